### rtl/tricolor_bitplane_pixel_writer_core_assert.svh
`ifndef TRICOLOR_BITPLANE_PIXEL_WRITER_CORE_ASSERT_SVH
`define TRICOLOR_BITPLANE_PIXEL_WRITER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TBPW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define TBPW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tbpw_pkg.sv
package tbpw_pkg;

	typedef enum logic [1:0] {
		OP_DRAW = 2'd0,
		OP_FILL = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CLR_WHITE,
		CLR_BLACK,
		CLR_RED
	} color_t;

	typedef enum logic [1:0] {
		ROT_0,
		ROT_90,
		ROT_180,
		ROT_270
	} rot_t;

	typedef enum logic [1:0] {
		REG_ROTATION,
		REG_WHITE_CODE,
		REG_BLACK_CODE,
		REG_RED_CODE
	} reg_index_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_RMW,
		BK_READ,
		BK_FILL
	} back_state_t;

	localparam logic [15:0] RED_MASK   = 16'hF100;
	localparam logic [15:0] GREEN_MASK = 16'h07E0;
	localparam logic [15:0] BLUE_MASK  = 16'h001F;
	localparam logic [15:0] RED_LIMIT  = 16'(32'hF100 / 2);
	localparam logic [15:0] LUMA_LIMIT = 16'(3 * 255 / 2);
	localparam logic [7:0]  BYTE_ONES  = 8'hFF;
	localparam logic [7:0]  BYTE_ZEROS = 8'h00;
	localparam logic [7:0]  LEFT_PIXEL = 8'h80;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		rot_t        rotation;
		logic [15:0] white_code;
		logic [15:0] black_code;
		logic [15:0] red_code;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		color_t     klass;
		logic [2:0] bit_pos;
		logic       plane;
		logic       in_range;
	} cmd_t;

	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_status_t;

	function automatic color_t classify(logic [15:0] c, cfg_t cfg);
		logic [15:0] sum;
		sum = ((c & RED_MASK) >> 11) + ((c & GREEN_MASK) >> 5) + (c & BLUE_MASK);
		priority if (c == cfg.white_code) begin
			return CLR_WHITE;
		end else if (c == cfg.black_code) begin
			return CLR_BLACK;
		end else if (c == cfg.red_code) begin
			return CLR_RED;
		end else if ((c & RED_MASK) > RED_LIMIT) begin
			return CLR_RED;
		end else if (sum < LUMA_LIMIT) begin
			return CLR_BLACK;
		end else begin
			return CLR_WHITE;
		end
	endfunction

endpackage

### rtl/tbpw_front.sv
module tbpw_front #(
	parameter int PANEL_WIDTH  = 960,
	parameter int PANEL_HEIGHT = 640,
	parameter int PLANE_BYTES  = 76800,
	parameter int AW           = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic signed [15:0]   pos_x,
	input  logic signed [15:0]   pos_y,
	input  logic [15:0]          pixel_color,
	input  logic                 plane_select,
	input  logic [16:0]          byte_index,
	input  tbpw_pkg::cfg_t       cfg,
	input  tbpw_pkg::q_status_t  q_stat,
	input  logic                 clearing,
	output logic                 push,
	output tbpw_pkg::cmd_t       push_cmd,
	output logic [AW-1:0]        push_addr
);
	import tbpw_pkg::*;

	localparam int MAXD = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
	localparam int CW   = $clog2(MAXD);
	localparam int XW   = $clog2(PANEL_WIDTH);
	localparam int YW   = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
	localparam int PW   = YW + $clog2(PANEL_WIDTH + 1);
	localparam int SW   = PW - 2;

	logic              accept;
	logic [15:0]       lw;
	logic [15:0]       lh;
	logic              in_bounds;
	logic              keep;
	logic [CW-1:0]     xs;
	logic [CW-1:0]     ys;
	logic [XW-1:0]     px;
	logic [YW-1:0]     py;
	cmd_t              cmd;
	logic [QCNT_W:0]   occupancy;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [XW-1:0]     px_s1;
	logic [YW-1:0]     py_s1;
	logic [AW-1:0]     rd_addr_s1;

	logic [PW-1:0]     prod;
	logic [SW-1:0]     sum;
	logic              in_plane;

	always_comb begin
		occupancy = (QCNT_W + 1)'(q_stat.count) + (QCNT_W + 1)'(valid_s1);
		busy = clearing || (occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH));
		accept = start && !busy;
	end

	always_comb begin
		lw = cfg.rotation[0] ? 16'(PANEL_HEIGHT) : 16'(PANEL_WIDTH);
		lh = cfg.rotation[0] ? 16'(PANEL_WIDTH) : 16'(PANEL_HEIGHT);
		in_bounds = !pos_x[15] && !pos_y[15]
			&& ($unsigned(pos_x) < lw) && ($unsigned(pos_y) < lh);
		xs = pos_x[CW-1:0];
		ys = pos_y[CW-1:0];
		unique case (cfg.rotation)
			ROT_0: begin
				px = XW'(xs);
				py = YW'(ys);
			end
			ROT_90: begin
				px = XW'(CW'(PANEL_WIDTH - 1) - ys);
				py = YW'(xs);
			end
			ROT_180: begin
				px = XW'(CW'(PANEL_WIDTH - 1) - xs);
				py = YW'(CW'(PANEL_HEIGHT - 1) - ys);
			end
			ROT_270: begin
				px = XW'(ys);
				py = YW'(CW'(PANEL_HEIGHT - 1) - xs);
			end
		endcase
		unique case (req_type)
			OP_DRAW: keep = in_bounds;
			OP_FILL: keep = 1'b1;
			OP_READ: keep = 1'b1;
			default: keep = 1'b0;
		endcase
		cmd.op       = op_t'(req_type);
		cmd.klass    = classify(pixel_color, cfg);
		cmd.bit_pos  = px[2:0];
		cmd.plane    = plane_select;
		cmd.in_range = 32'(byte_index) < 32'(PLANE_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd;
			px_s1      <= px;
			py_s1      <= py;
			rd_addr_s1 <= AW'(byte_index);
		end
	end

	always_comb begin
		prod      = PW'(py_s1) * PW'(PANEL_WIDTH);
		sum       = SW'(prod >> 3) + SW'(px_s1 >> 3);
		in_plane  = 32'(sum) < 32'(PLANE_BYTES);
		push      = valid_s1 && ((cmd_s1.op != OP_DRAW) || in_plane);
		push_cmd  = cmd_s1;
		push_addr = (cmd_s1.op == OP_DRAW) ? AW'(sum) : rd_addr_s1;
	end

endmodule

### rtl/tbpw_queue.sv
module tbpw_queue #(
	parameter int AW = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tbpw_pkg::cmd_t      push_cmd,
	input  logic [AW-1:0]       push_addr,
	input  logic                pop,
	output tbpw_pkg::cmd_t      head_cmd,
	output logic [AW-1:0]       head_addr,
	output tbpw_pkg::q_status_t q_stat
);
	import tbpw_pkg::*;

	cmd_t              cmd_fifo_q  [QUEUE_DEPTH];
	logic [AW-1:0]     addr_fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_fifo_q[wr_ptr_q]  <= push_cmd;
			addr_fifo_q[wr_ptr_q] <= push_addr;
		end
	end

	always_comb begin
		head_cmd     = cmd_fifo_q[rd_ptr_q];
		head_addr    = addr_fifo_q[rd_ptr_q];
		q_stat.empty = (count_q == '0);
		q_stat.count = count_q;
	end

endmodule

### rtl/tbpw_back.sv
module tbpw_back #(
	parameter int PLANE_BYTES = 76800,
	parameter int AW          = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tbpw_pkg::q_status_t q_stat,
	input  tbpw_pkg::cmd_t      head_cmd,
	input  logic [AW-1:0]       head_addr,
	output logic                pop,
	output logic                clearing,
	output logic                done,
	output logic [7:0]          read_data
);
	import tbpw_pkg::*;

	logic [7:0]    black_plane_q [PLANE_BYTES];
	logic [7:0]    red_plane_q   [PLANE_BYTES];

	back_state_t   state_q;
	back_state_t   next_state;
	logic [AW-1:0] sweep_q;
	cmd_t          cur_cmd_q;
	logic [AW-1:0] cur_addr_q;
	logic [7:0]    blk_rd_q;
	logic [7:0]    red_rd_q;

	logic          sweep_last;
	logic [7:0]    mask;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    wdata_blk;
	logic [7:0]    wdata_red;

	assign sweep_last = (sweep_q == AW'(PLANE_BYTES - 1));
	assign mask       = LEFT_PIXEL >> cur_cmd_q.bit_pos;

	always_comb begin
		next_state = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (sweep_last) begin
					next_state = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_stat.empty) begin
					unique case (head_cmd.op)
						OP_DRAW: next_state = BK_RMW;
						OP_FILL: next_state = BK_FILL;
						OP_READ: next_state = BK_READ;
						default: next_state = BK_IDLE;
					endcase
				end
			end
			BK_RMW:  next_state = BK_IDLE;
			BK_READ: next_state = BK_IDLE;
			BK_FILL: begin
				if (sweep_last) begin
					next_state = BK_IDLE;
				end
			end
			default: next_state = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cur_addr_q;
		wdata_blk = BYTE_ZEROS;
		wdata_red = BYTE_ZEROS;
		done      = 1'b0;
		read_data = BYTE_ZEROS;
		clearing  = (state_q == BK_CLEAR);
		unique case (state_q)
			BK_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
			end
			BK_IDLE: begin
				pop = !q_stat.empty;
			end
			BK_RMW: begin
				mem_we    = 1'b1;
				wdata_blk = (blk_rd_q & ~mask)
					| ((cur_cmd_q.klass == CLR_BLACK) ? mask : BYTE_ZEROS);
				wdata_red = (red_rd_q & ~mask)
					| ((cur_cmd_q.klass == CLR_RED) ? mask : BYTE_ZEROS);
			end
			BK_READ: begin
				done = 1'b1;
				if (cur_cmd_q.in_range) begin
					read_data = cur_cmd_q.plane ? red_rd_q : ~blk_rd_q;
				end
			end
			BK_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				wdata_blk = (cur_cmd_q.klass == CLR_BLACK) ? BYTE_ONES : BYTE_ZEROS;
				wdata_red = (cur_cmd_q.klass == CLR_RED) ? BYTE_ONES : BYTE_ZEROS;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			sweep_q <= '0;
		end else begin
			state_q <= next_state;
			if ((state_q == BK_CLEAR || state_q == BK_FILL) && !sweep_last) begin
				sweep_q <= sweep_q + AW'(1);
			end else begin
				sweep_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_cmd_q  <= head_cmd;
			cur_addr_q <= head_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			black_plane_q[mem_waddr] <= wdata_blk;
			red_plane_q[mem_waddr]   <= wdata_red;
		end
		blk_rd_q <= black_plane_q[head_addr];
		red_rd_q <= red_plane_q[head_addr];
	end

endmodule

### rtl/tricolor_bitplane_pixel_writer_core.sv
// Two-plane black/white/red framebuffer. An item is taken when start is high
// and busy is low; a read gives one byte on read_data with done high for one
// cycle, and the receiver cannot stall it. A read result appears once its item
// has passed the front stage register, the queue and the back end's state
// register. The back end works on one item at a time against plane memories
// with one read and one write port: a draw reads its byte as it is popped and
// writes it back in the read-modify-write state, a read returns the byte read
// as it is popped, and a fill writes every plane byte in turn. Up to four items
// wait in the front stage and the queue together; busy rises when four are held.
// After reset a clearing pass writes white to every byte, one byte a cycle,
// with busy high throughout; configuration writes are taken at any time.
module tricolor_bitplane_pixel_writer_core #(
	parameter int PANEL_WIDTH  = 960,
	parameter int PANEL_HEIGHT = 640
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [15:0]        pixel_color,
	input  logic               plane_select,
	input  logic [16:0]        byte_index,
	output logic               done,
	output logic [7:0]         read_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import tbpw_pkg::*;

	localparam int PLANE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
	localparam int AW          = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;

	cfg_t          cfg_q;
	q_status_t     q_stat;
	logic          clearing;
	logic          push;
	cmd_t          push_cmd;
	logic [AW-1:0] push_addr;
	logic          pop;
	cmd_t          head_cmd;
	logic [AW-1:0] head_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation   <= ROT_0;
			cfg_q.white_code <= 16'hFFFF;
			cfg_q.black_code <= 16'h0000;
			cfg_q.red_code   <= 16'hF800;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_ROTATION:   cfg_q.rotation   <= rot_t'(cfg_data[1:0]);
				REG_WHITE_CODE: cfg_q.white_code <= cfg_data;
				REG_BLACK_CODE: cfg_q.black_code <= cfg_data;
				REG_RED_CODE:   cfg_q.red_code   <= cfg_data;
			endcase
		end
	end

	tbpw_front #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT),
		.PLANE_BYTES (PLANE_BYTES),
		.AW          (AW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pixel_color (pixel_color),
		.plane_select(plane_select),
		.byte_index  (byte_index),
		.cfg         (cfg_q),
		.q_stat      (q_stat),
		.clearing    (clearing),
		.push        (push),
		.push_cmd    (push_cmd),
		.push_addr   (push_addr)
	);

	tbpw_queue #(
		.AW(AW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.push_addr(push_addr),
		.pop      (pop),
		.head_cmd (head_cmd),
		.head_addr(head_addr),
		.q_stat   (q_stat)
	);

	tbpw_back #(
		.PLANE_BYTES(PLANE_BYTES),
		.AW         (AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head_cmd (head_cmd),
		.head_addr(head_addr),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.read_data(read_data)
	);

endmodule

### rtl/tbpw_checker.sv
`include "tricolor_bitplane_pixel_writer_core_assert.svh"

module tbpw_checker (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic done
);

	`TBPW_ASSERT_IMP(a_clear_after_reset, !$past(arst_n), busy && !done, "no clearing pass after reset")
	`TBPW_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")
	`TBPW_ASSERT_IMP(a_done_latency, done, $past(arst_n, 3), "result too soon after reset")

endmodule

bind tricolor_bitplane_pixel_writer_core tbpw_checker u_tbpw_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.busy  (busy),
	.done  (done)
);
